FILE: rtl/text_terminal_cell_renderer_unit_defines.svh
// Assertion macros shared by the terminal renderer modules.
`ifndef TEXT_TERMINAL_CELL_RENDERER_UNIT_DEFINES_SVH
`define TEXT_TERMINAL_CELL_RENDERER_UNIT_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define TTCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define TTCR_ASSERT_NEXT(label, cond, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (post)) else $error(msg);

`endif

FILE: rtl/ttcr_pkg.sv
// Shared constants, types and font table of the terminal cell renderer.
package ttcr_pkg;

   localparam int TEXT_COLS = 40;
   localparam int TEXT_ROWS = 40;
   localparam int TAB_WIDTH = 8;
   localparam int POS_W = 6;
   localparam int CNT_W = $clog2(TAB_WIDTH + 1);
   localparam int GLYPH_W = 48;
   localparam int GLYPH_COUNT = 95;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;

   localparam logic [1:0] OP_PUT = 2'd0;
   localparam logic [1:0] OP_CURSOR = 2'd1;
   localparam logic [1:0] OP_LATCH = 2'd2;

   localparam logic [1:0] ACT_DRAW = 2'd0;
   localparam logic [1:0] ACT_ROW_CLEAR = 2'd1;
   localparam logic [1:0] ACT_WIN_CLEAR = 2'd2;
   localparam logic [1:0] ACT_REJECT = 2'd3;

   localparam logic [1:0] REG_TOP = 2'd0;
   localparam logic [1:0] REG_LEFT = 2'd1;
   localparam logic [1:0] REG_ROWS = 2'd2;
   localparam logic [1:0] REG_COLS = 2'd3;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_QMARK = 7'h3F;
   localparam logic [6:0] GLYPH_FIRST = 7'h20;
   localparam logic [6:0] GLYPH_LAST = 7'h7E;

   typedef struct packed {
      logic [POS_W-1:0] top;
      logic [POS_W-1:0] left;
      logic [POS_W-1:0] rows;
      logic [POS_W-1:0] cols;
   } window_type;

   // A run is an optional clear or status result followed by a row of draws.
   typedef struct packed {
      logic             pre_valid;
      logic [1:0]       pre_action;
      logic [POS_W-1:0] pre_row;
      logic [POS_W-1:0] pre_col;
      logic [CNT_W-1:0] cnt;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [6:0]       ch;
   } run_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [GLYPH_W-1:0] glyph;
      logic [6:0]         ch;
      logic               last;
   } rsp_type;

   // Column k of a glyph sits in bits 8k+7..8k, bit j is pixel row j.
   localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      48'h0000_0000_0000, 48'h0000_002E_0000, 48'h0000_0600_0600, 48'h143E_143E_1400,
      48'h0014_762C_2800, 48'h2006_0830_0200, 48'h2810_2A2A_1400, 48'h0000_0006_0000,
      48'h0000_221C_0000, 48'h0000_1C22_0000, 48'h0000_0A04_0A00, 48'h0000_081C_0800,
      48'h0000_0020_4000, 48'h0000_0808_0800, 48'h0000_0020_0000, 48'h0204_0810_2000,
      48'h001C_2222_1C00, 48'h0000_3E02_0000, 48'h0024_2A2A_3200, 48'h0014_2A2A_2200,
      48'h0010_3E14_1800, 48'h0012_2A2A_2E00, 48'h0010_2A2A_1C00, 48'h0006_0A32_0200,
      48'h0014_2A2A_1400, 48'h001C_2A2A_0400, 48'h0000_0014_0000, 48'h0000_0024_4000,
      48'h0000_2214_0800, 48'h0000_1414_1400, 48'h0000_0814_2200, 48'h0004_0A2A_0200,
      48'h1C2A_3A22_1C00, 48'h003C_1212_3C00, 48'h0014_2A2A_3E00, 48'h0000_2222_1C00,
      48'h001C_2222_3E00, 48'h0000_2A2A_3E00, 48'h0000_0A0A_3E00, 48'h003A_2A22_1C00,
      48'h003E_0808_3E00, 48'h0000_223E_2200, 48'h001E_2220_1000, 48'h0022_1408_3E00,
      48'h0000_2020_3E00, 48'h3E04_0804_3E00, 48'h003E_0804_3E00, 48'h001C_2222_1C00,
      48'h000C_1212_3E00, 48'h005C_2222_1C00, 48'h002C_1212_3E00, 48'h0012_2A2A_2400,
      48'h0000_023E_0200, 48'h001E_2020_1E00, 48'h0006_1820_1E00, 48'h1E20_1C20_1E00,
      48'h0036_0808_3600, 48'h001E_2828_0600, 48'h0000_262A_3200, 48'h0000_223E_0000,
      48'h2010_0804_0200, 48'h0000_3E22_0000, 48'h0000_0402_0400, 48'h0020_2020_2000,
      48'h0000_0402_0000, 48'h003C_2424_1800, 48'h0018_2424_3E00, 48'h0000_2424_1800,
      48'h003E_2424_1800, 48'h0008_2C34_1800, 48'h0000_0A3C_0800, 48'h007C_A4A4_1800,
      48'h0038_0404_3E00, 48'h0000_003A_0000, 48'h0000_7A80_0000, 48'h0024_1810_3E00,
      48'h0000_003E_0000, 48'h3804_3C04_3C00, 48'h0038_0404_3C00, 48'h0018_2424_1800,
      48'h0018_2424_FC00, 48'h00FC_2424_1800, 48'h0000_0408_3C00, 48'h0014_342C_2800,
      48'h0000_241E_0400, 48'h003C_2020_1C00, 48'h000C_1020_1C00, 48'h0C30_0C30_0C00,
      48'h0000_2418_2400, 48'h007C_A0A0_1C00, 48'h0024_2C34_2400, 48'h0000_2236_0800,
      48'h0000_003E_0000, 48'h0000_0836_2200, 48'h0002_0402_0400
   };

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [6:0] ch);
      logic [6:0] idx;
      idx = ch - GLYPH_FIRST;
      if (ch >= GLYPH_FIRST && ch <= GLYPH_LAST) begin
         return GLYPH_ROM[idx];
      end
      return '0;
   endfunction

endpackage

FILE: rtl/text_terminal_cell_renderer_unit.sv
// Top level of the text terminal cell renderer.
// Commands arrive on the req_ stream: tuser carries the opcode (put character, set
// cursor relative to the window, latch window and clear) and tdata its operands.
// Each command yields zero to nine results on the rsp_ stream: cell draws with a
// 6x8 glyph, row clears, window clears or a window rejection; tlast marks the final
// result of a command. The csr_ channel writes the window registers and is always
// ready; the user writes it only while no command is in flight; the block does not enforce this.
// Each command is planned against the cursor state into the run register, and each
// result then passes through the output register.
// A command is taken every cycle while runs hold one result each and the receiver
// keeps up; a command with several results holds req_tready low while the run register
// drains, one result per cycle unless the receiver stalls. When the receiver stalls the output
// register holds its result, and the next command is still taken as the current run finishes.
// Reset clears the cursor to the top left corner, makes the whole 40 by 40 screen
// the active window, loads the window registers with the same window, and empties
// the run and output registers.
module text_terminal_cell_renderer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ttcr_pkg::REQ_DATA_W-1:0] req_tdata,  // char_code, cursor_row_rel, cursor_col_rel
   input  logic [1:0]                      req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ttcr_pkg::RSP_DATA_W-1:0] rsp_tdata,  // cell_row, cell_col, glyph_bits, shown_char
   output logic [1:0]                      rsp_tuser,  // action
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [ttcr_pkg::POS_W-1:0]      csr_wdata
);
   import ttcr_pkg::*;

   window_type window_ff, window_in;
   logic       req_fire;
   logic       can_load;
   run_type    plan;
   rsp_type    rsp;

   always_comb begin
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TOP: window_in.top = csr_wdata;
            REG_LEFT: window_in.left = csr_wdata;
            REG_ROWS: window_in.rows = csr_wdata;
            REG_COLS: window_in.cols = csr_wdata;
            default: window_in = window_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.top <= '0;
         window_ff.left <= '0;
         window_ff.rows <= POS_W'(TEXT_ROWS);
         window_ff.cols <= POS_W'(TEXT_COLS);
      end else begin
         window_ff <= window_in;
      end
   end

   assign csr_ready = 1'b1;
   assign req_tready = can_load;
   assign req_fire = req_tvalid && can_load;

   ttcr_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .opcode         (req_tuser),
      .char_code      (req_tdata[7:0]),
      .cursor_row_rel (req_tdata[13:8]),
      .cursor_col_rel (req_tdata[19:14]),
      .window         (window_ff),
      .plan           (plan)
   );

   ttcr_run u_run (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .plan      (plan),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.ch, rsp.glyph, rsp.col, rsp.row};
   assign rsp_tuser = rsp.action;
   assign rsp_tlast = rsp.last;

endmodule

FILE: rtl/ttcr_decode.sv
// Command decoder that keeps the cursor and active window and plans each result run.
`include "text_terminal_cell_renderer_unit_defines.svh"

module ttcr_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_fire,
   input  logic [1:0]                  opcode,
   input  logic [7:0]                  char_code,
   input  logic [ttcr_pkg::POS_W-1:0]  cursor_row_rel,
   input  logic [ttcr_pkg::POS_W-1:0]  cursor_col_rel,
   input  ttcr_pkg::window_type        window,
   output ttcr_pkg::run_type           plan
);
   import ttcr_pkg::*;

   logic [POS_W-1:0] cur_row_ff, cur_row_in;
   logic [POS_W-1:0] cur_col_ff, cur_col_in;
   logic [POS_W-1:0] top_ff, top_in;
   logic [POS_W-1:0] left_ff, left_in;
   logic [POS_W-1:0] end_row_ff, end_row_in;
   logic [POS_W-1:0] end_col_ff, end_col_in;

   logic [POS_W:0]   row_plus;
   logic [POS_W-1:0] wrap_row;
   logic             wrap;
   logic [POS_W-1:0] base_row;
   logic [POS_W-1:0] base_col;
   logic [POS_W:0]   tab_stop;
   logic [POS_W:0]   tab_end;
   logic [CNT_W-1:0] tab_cnt;
   logic             printable;
   logic [6:0]       shown;
   logic [POS_W-1:0] win_h;
   logic [POS_W-1:0] win_w;
   logic [POS_W-1:0] sat_row;
   logic [POS_W-1:0] sat_col;
   logic [POS_W:0]   row_span;
   logic [POS_W:0]   col_span;
   logic             win_ok;

   always_comb begin
      row_plus = {1'b0, cur_row_ff} + (POS_W+1)'(1);
      wrap_row = (row_plus >= {1'b0, end_row_ff}) ? top_ff : row_plus[POS_W-1:0];
      wrap = (char_code == CH_LF) || (cur_col_ff >= end_col_ff);
      base_row = wrap ? wrap_row : cur_row_ff;
      base_col = wrap ? left_ff : cur_col_ff;
      tab_stop = (POS_W+1)'((({1'b0, base_col} / TAB_WIDTH) + 1) * TAB_WIDTH);
      tab_end = (tab_stop > {1'b0, end_col_ff}) ? {1'b0, end_col_ff} : tab_stop;
      tab_cnt = CNT_W'(tab_end - {1'b0, base_col});
      printable = char_code inside {[8'h20:8'h7E]};
      shown = printable ? char_code[6:0] : CH_QMARK;

      win_h = end_row_ff - top_ff;
      win_w = end_col_ff - left_ff;
      sat_row = (cursor_row_rel >= win_h) ? win_h - POS_W'(1) : cursor_row_rel;
      sat_col = (cursor_col_rel >= win_w) ? win_w - POS_W'(1) : cursor_col_rel;

      row_span = {1'b0, window.top} + {1'b0, window.rows};
      col_span = {1'b0, window.left} + {1'b0, window.cols};
      win_ok = (window.top < POS_W'(TEXT_ROWS)) && (window.left < POS_W'(TEXT_COLS)) &&
               (window.rows != '0) && (window.cols != '0) &&
               (row_span <= (POS_W+1)'(TEXT_ROWS)) && (col_span <= (POS_W+1)'(TEXT_COLS));
   end

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      top_in = top_ff;
      left_in = left_ff;
      end_row_in = end_row_ff;
      end_col_in = end_col_ff;
      plan = '0;
      if (req_fire) begin
         case (opcode)
            OP_PUT: begin
               case (char_code)
                  CH_NUL: begin
                  end
                  CH_CR: begin
                     cur_col_in = left_ff;
                  end
                  CH_VT: begin
                     cur_row_in = top_ff;
                  end
                  CH_FF: begin
                     cur_row_in = top_ff;
                     cur_col_in = left_ff;
                     plan.pre_valid = 1'b1;
                     plan.pre_action = ACT_WIN_CLEAR;
                     plan.pre_row = top_ff;
                     plan.pre_col = left_ff;
                  end
                  default: begin
                     cur_row_in = base_row;
                     cur_col_in = base_col;
                     if (wrap) begin
                        plan.pre_valid = 1'b1;
                        plan.pre_action = ACT_ROW_CLEAR;
                        plan.pre_row = wrap_row;
                        plan.pre_col = left_ff;
                     end
                     plan.row = base_row;
                     plan.col = base_col;
                     if (char_code == CH_TAB) begin
                        plan.cnt = tab_cnt;
                        plan.ch = CH_SPACE;
                        cur_col_in = tab_end[POS_W-1:0];
                     end else if (char_code != CH_LF) begin
                        plan.cnt = CNT_W'(1);
                        plan.ch = shown;
                        cur_col_in = base_col + POS_W'(1);
                     end
                  end
               endcase
            end
            OP_CURSOR: begin
               cur_row_in = top_ff + sat_row;
               cur_col_in = left_ff + sat_col;
            end
            OP_LATCH: begin
               plan.pre_valid = 1'b1;
               if (win_ok) begin
                  top_in = window.top;
                  left_in = window.left;
                  end_row_in = row_span[POS_W-1:0];
                  end_col_in = col_span[POS_W-1:0];
                  cur_row_in = window.top;
                  cur_col_in = window.left;
                  plan.pre_action = ACT_WIN_CLEAR;
                  plan.pre_row = window.top;
                  plan.pre_col = window.left;
               end else begin
                  plan.pre_action = ACT_REJECT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         top_ff <= '0;
         left_ff <= '0;
         end_row_ff <= POS_W'(TEXT_ROWS);
         end_col_ff <= POS_W'(TEXT_COLS);
      end else begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         top_ff <= top_in;
         left_ff <= left_in;
         end_row_ff <= end_row_in;
         end_col_ff <= end_col_in;
      end
   end

   // The cursor row stays inside the window; the column may sit one past its right edge.
   `TTCR_ASSERT(a_row_in_window, cur_row_ff >= top_ff && cur_row_ff < end_row_ff, "cursor row outside window")
   `TTCR_ASSERT(a_col_in_window, cur_col_ff >= left_ff && cur_col_ff <= end_col_ff, "cursor column outside window")
   `TTCR_ASSERT(a_window_nonempty, end_row_ff > top_ff && end_col_ff > left_ff, "active window is empty")

endmodule

FILE: rtl/ttcr_run.sv
// Result run register and output register that issue one result per transaction.
`include "text_terminal_cell_renderer_unit_defines.svh"

module ttcr_run (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ttcr_pkg::run_type plan,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttcr_pkg::rsp_type rsp
);
   import ttcr_pkg::*;

   run_type run_ff, run_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic    run_valid;
   logic    advance;
   logic    run_final;
   rsp_type elem;

   always_comb begin
      run_valid = run_ff.pre_valid || (run_ff.cnt != '0);
      advance = run_valid && (!out_valid_ff || rsp_ready);
      if (run_ff.pre_valid) begin
         elem.action = run_ff.pre_action;
         elem.row = run_ff.pre_row;
         elem.col = run_ff.pre_col;
         elem.glyph = '0;
         elem.ch = CH_SPACE;
         elem.last = (run_ff.cnt == '0);
      end else begin
         elem.action = ACT_DRAW;
         elem.row = run_ff.row;
         elem.col = run_ff.col;
         elem.glyph = glyph_of(run_ff.ch);
         elem.ch = run_ff.ch;
         elem.last = (run_ff.cnt == CNT_W'(1));
      end
      run_final = run_valid && elem.last;
      can_load = !run_valid || (run_final && advance);

      run_in = run_ff;
      if (advance) begin
         if (run_ff.pre_valid) begin
            run_in.pre_valid = 1'b0;
         end else begin
            run_in.cnt = run_ff.cnt - CNT_W'(1);
            run_in.col = run_ff.col + POS_W'(1);
         end
      end
      if (load) begin
         run_in = plan;
      end

      out_in = advance ? elem : out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

   `TTCR_ASSERT(a_cnt_bound, run_ff.cnt <= CNT_W'(TAB_WIDTH), "draw count exceeds a tab span")
   `TTCR_ASSERT_NEXT(a_run_continues, advance && !run_final, run_valid, "run ended before its last result")
   `TTCR_ASSERT_NEXT(a_out_filled, advance, out_valid_ff, "issued result not held in output register")

endmodule
